[rtl/pcc_pkg.sv]
// Shared types and constants of the permutation cycle composer.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package pcc_pkg;

  localparam int POINT_W    = 5;   // element and point fields
  localparam int CFG_W      = 6;   // point count register
  localparam int RESULT_CAP = 32;  // most result beats for one product
  localparam int KCNT_W     = 6;   // holds 0 .. RESULT_CAP
  localparam int CFG_RESET  = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELEM,
    ST_CLOSE,
    ST_INV,
    ST_DRAIN,
    ST_SCAN,
    ST_STEP,
    ST_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch the input beat and read the position entry
    logic elem;       // apply the element to the carried value
    logic close;      // write the carried value back to the cycle start
    logic inv_read;   // inversion sweep: read one position entry
    logic emit_init;  // clear visited marks and emission counters
    logic scan_skip;  // advance the outer scan point
    logic scan_open;  // mark the scan point and read its inverse
    logic push;       // queue the current walk point as a result
    logic walk_next;  // follow the inverse to the next point
    logic flush;      // send the final beat and clear the product
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_close;
    logic prod_end;
    logic inv_last;
    logic scan_done;
    logic vis_i;
    logic stop;
    logic at_start;
    logic cap_hit;
    logic can_push;
    logic out_free;
  } sts_t;

endpackage

[rtl/pcc_if.sv]
// Channel interfaces of the permutation cycle composer: input, result and
// configuration. Depends on pcc_pkg for the field widths.
interface pcc_in_if;
  logic                         valid;
  logic                         ready;
  logic [pcc_pkg::POINT_W-1:0]  element;
  logic                         cycle_end;
  logic                         product_end;

  modport source(output valid, element, cycle_end, product_end, input ready);
  modport sink(input valid, element, cycle_end, product_end, output ready);
endinterface

interface pcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [pcc_pkg::POINT_W-1:0]  point;
  logic                         closes_cycle;
  logic                         is_identity;
  logic                         last;

  modport source(output valid, point, closes_cycle, is_identity, last, input ready);
  modport sink(input valid, point, closes_cycle, is_identity, last, output ready);
endinterface

interface pcc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pcc_pkg::CFG_W-1:0]   data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[rtl/pcc_ctrl.sv]
// Controller of the permutation cycle composer: sequences element updates,
// the inversion sweep and the emission walk. Depends on pcc_pkg.
module pcc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pcc_pkg::sts_t   sts,
  output pcc_pkg::cmd_t   cmd
);

  pcc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      pcc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = pcc_pkg::ST_ELEM;
        end
      end
      pcc_pkg::ST_ELEM: begin
        cmd.elem = 1'b1;
        if (sts.need_close) begin
          state_nxt = pcc_pkg::ST_CLOSE;
        end else if (sts.prod_end) begin
          state_nxt = pcc_pkg::ST_INV;
        end else begin
          state_nxt = pcc_pkg::ST_IDLE;
        end
      end
      pcc_pkg::ST_CLOSE: begin
        cmd.close = 1'b1;
        state_nxt = sts.prod_end ? pcc_pkg::ST_INV : pcc_pkg::ST_IDLE;
      end
      pcc_pkg::ST_INV: begin
        cmd.inv_read = 1'b1;
        if (sts.inv_last) begin
          state_nxt = pcc_pkg::ST_DRAIN;
        end
      end
      pcc_pkg::ST_DRAIN: begin
        // The last inverse write lands in this cycle, before any walk read.
        cmd.emit_init = 1'b1;
        state_nxt     = pcc_pkg::ST_SCAN;
      end
      pcc_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = pcc_pkg::ST_FLUSH;
        end else if (sts.vis_i) begin
          cmd.scan_skip = 1'b1;
        end else begin
          cmd.scan_open = 1'b1;
          state_nxt     = pcc_pkg::ST_STEP;
        end
      end
      pcc_pkg::ST_STEP: begin
        if (sts.at_start && sts.stop) begin
          // A fixed point, or a walk that goes nowhere: dropped.
          cmd.scan_skip = 1'b1;
          state_nxt     = pcc_pkg::ST_SCAN;
        end else if (sts.can_push) begin
          cmd.push = 1'b1;
          if (sts.stop) begin
            cmd.scan_skip = 1'b1;
            state_nxt     = pcc_pkg::ST_SCAN;
          end else if (sts.cap_hit) begin
            state_nxt = pcc_pkg::ST_FLUSH;
          end else begin
            cmd.walk_next = 1'b1;
          end
        end
      end
      pcc_pkg::ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = pcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pcc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/pcc_dp.sv]
// Datapath of the permutation cycle composer: position and inverse memories,
// visited marks, walk registers and the result queue. Depends on pcc_pkg.
module pcc_dp #(
  parameter int MAX_POINTS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pcc_pkg::POINT_W-1:0]   in_element,
  input  logic                          in_cycle_end,
  input  logic                          in_product_end,
  input  logic                          cfg_wr,
  input  logic [pcc_pkg::CFG_W-1:0]     cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pcc_pkg::POINT_W-1:0]   out_point,
  output logic                          out_closes_cycle,
  output logic                          out_is_identity,
  output logic                          out_last,
  input  pcc_pkg::cmd_t                 cmd,
  output pcc_pkg::sts_t                 sts
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = (CNT_W > pcc_pkg::CFG_W) ? CNT_W : pcc_pkg::CFG_W;
  localparam logic [CMP_W-1:0] MAXP = CMP_W'(MAX_POINTS);

  // Point count register and the effective count n.
  logic [pcc_pkg::CFG_W-1:0] pc_r;
  logic [CMP_W-1:0]          pc_ext, n_ext;
  logic [CNT_W-1:0]          n, n_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= pcc_pkg::CFG_W'(pcc_pkg::CFG_RESET);
    end else if (cfg_wr) begin
      pc_r <= cfg_data;
    end
  end

  assign pc_ext = CMP_W'(pc_r);
  assign n_ext  = (pc_r == '0) ? CMP_W'(1) : ((pc_ext > MAXP) ? MAXP : pc_ext);
  assign n      = n_ext[CNT_W-1:0];
  assign n_m1   = n - CNT_W'(1);

  // Latched input beat.
  logic [pcc_pkg::POINT_W-1:0] el_r;
  logic                        ce_r, pe_r, e_ok_r;
  logic [IDX_W-1:0]            e_idx, el_idx;

  assign e_idx  = IDX_W'(in_element);
  assign el_idx = IDX_W'(el_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      el_r   <= in_element;
      ce_r   <= in_cycle_end;
      pe_r   <= in_product_end;
      e_ok_r <= CMP_W'(in_element) < n_ext;
    end
  end

  // Position memory; an entry without its valid bit reads as its own index.
  logic [IDX_W-1:0]      pm_mem [MAX_POINTS];
  logic [MAX_POINTS-1:0] pm_vld_r;
  logic [IDX_W-1:0]      pm_rdata_r, pm_raddr_r, pm_raddr, pm_waddr, pm_val;
  logic                  pm_rvld_r, pm_re, pm_we;
  logic [IDX_W-1:0]      carried_r, first_r, idx_r;
  logic                  in_cycle_r;

  assign pm_re    = cmd.accept | cmd.inv_read;
  assign pm_raddr = cmd.accept ? e_idx : idx_r;
  assign pm_we    = (cmd.elem & e_ok_r & in_cycle_r) | cmd.close;
  assign pm_waddr = cmd.close ? first_r : el_idx;
  assign pm_val   = pm_rvld_r ? pm_rdata_r : pm_raddr_r;

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pm_mem[pm_waddr] <= carried_r;
    end
    if (pm_re) begin
      pm_rdata_r <= pm_mem[pm_raddr];
      pm_rvld_r  <= pm_vld_r[pm_raddr];
      pm_raddr_r <= pm_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_vld_r <= '0;
    end else if (cmd.flush) begin
      pm_vld_r <= '0;
    end else if (pm_we) begin
      pm_vld_r[pm_waddr] <= 1'b1;
    end
  end

  // Carried value of the open cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carried_r  <= '0;
      first_r    <= '0;
      in_cycle_r <= 1'b0;
    end else if (cmd.flush) begin
      carried_r  <= '0;
      first_r    <= '0;
      in_cycle_r <= 1'b0;
    end else if (cmd.close) begin
      in_cycle_r <= 1'b0;
    end else if (cmd.elem && e_ok_r) begin
      carried_r <= pm_val;
      if (!in_cycle_r) begin
        first_r    <= el_idx;
        in_cycle_r <= 1'b1;
      end
    end
  end

  // Inversion sweep: read stage on the position memory, write stage in the cycle after.
  logic             inv_wv_r;
  logic [IDX_W-1:0] inv_mem [MAX_POINTS];
  logic [IDX_W-1:0] inv_rd_r, inv_raddr, nx;
  logic             inv_re;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_wv_r <= 1'b0;
    end else begin
      inv_wv_r <= cmd.inv_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= '0;
    end else if (cmd.inv_read) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  assign inv_re    = cmd.scan_open | cmd.walk_next;
  assign nx        = inv_rd_r;

  always_ff @(posedge clk) begin
    if (inv_wv_r && (CNT_W'(pm_val) < n)) begin
      inv_mem[pm_val] <= pm_raddr_r;
    end
    if (inv_re) begin
      inv_rd_r <= inv_mem[inv_raddr];
    end
  end

  // Emission walk.
  logic [MAX_POINTS-1:0]      vis_r;
  logic [CNT_W-1:0]           i_r;
  logic [IDX_W-1:0]           i_idx, j_r;
  logic [pcc_pkg::KCNT_W-1:0] k_r;
  logic                       stop, cap_hit;

  assign i_idx     = i_r[IDX_W-1:0];
  assign inv_raddr = cmd.scan_open ? i_idx : nx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r <= '0;
    end else if (cmd.emit_init) begin
      vis_r <= '0;
    end else if (cmd.scan_open) begin
      vis_r[i_idx] <= 1'b1;
    end else if (cmd.walk_next) begin
      vis_r[nx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      i_r <= '0;
      k_r <= '0;
    end else begin
      if (cmd.scan_skip) begin
        i_r <= i_r + CNT_W'(1);
      end
      if (cmd.push) begin
        k_r <= k_r + pcc_pkg::KCNT_W'(1);
      end
    end
    if (cmd.scan_open) begin
      j_r <= i_idx;
    end else if (cmd.walk_next) begin
      j_r <= nx;
    end
  end

  // A walk stops when it returns to its start, leaves the point range or
  // meets a point already taken by an earlier cycle.
  assign stop    = (nx == i_idx) | (CNT_W'(nx) >= n) | vis_r[nx];
  assign cap_hit = (k_r == pcc_pkg::KCNT_W'(pcc_pkg::RESULT_CAP - 1));

  // Result queue: one pending item ahead of the output register, so that the
  // final beat can be flagged once the walk is known to be over.
  logic                        pend_vld_r, out_vld_r;
  logic [pcc_pkg::POINT_W-1:0] pend_pt_r, out_pt_r;
  logic                        pend_cl_r, out_cl_r, out_id_r, out_last_r;
  logic                        out_free, can_push, out_load;

  assign out_free = ~out_vld_r | out_ready;
  assign can_push = ~pend_vld_r | out_free;
  assign out_load = (cmd.push & pend_vld_r) | cmd.flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cmd.push) begin
        pend_vld_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      pend_pt_r <= pcc_pkg::POINT_W'(j_r);
      pend_cl_r <= stop | cap_hit;
    end
    if (cmd.push && pend_vld_r) begin
      out_pt_r   <= pend_pt_r;
      out_cl_r   <= pend_cl_r;
      out_id_r   <= 1'b0;
      out_last_r <= 1'b0;
    end else if (cmd.flush) begin
      out_last_r <= 1'b1;
      if (pend_vld_r) begin
        out_pt_r <= pend_pt_r;
        out_cl_r <= pend_cl_r;
        out_id_r <= 1'b0;
      end else begin
        out_pt_r <= '0;
        out_cl_r <= 1'b0;
        out_id_r <= 1'b1;
      end
    end
  end

  assign out_valid        = out_vld_r;
  assign out_point        = out_pt_r;
  assign out_closes_cycle = out_cl_r;
  assign out_is_identity  = out_id_r;
  assign out_last         = out_last_r;

  assign sts.need_close = (ce_r | pe_r) & (in_cycle_r | e_ok_r);
  assign sts.prod_end   = pe_r;
  assign sts.inv_last   = (CNT_W'(idx_r) == n_m1);
  assign sts.scan_done  = (i_r >= n) | (k_r == pcc_pkg::KCNT_W'(pcc_pkg::RESULT_CAP));
  assign sts.vis_i      = vis_r[i_idx];
  assign sts.stop       = stop;
  assign sts.at_start   = (j_r == i_idx);
  assign sts.cap_hit    = cap_hit;
  assign sts.can_push   = can_push;
  assign sts.out_free   = out_free;

endmodule

[rtl/permutation_cycle_composer.sv]
// Permutation cycle composer: composes a stream of cycles on a position map
// held in memory and emits the product in canonical cycle notation.
// Depends on pcc_pkg, the channel interfaces in pcc_if, pcc_ctrl and pcc_dp.
//
// Items are taken one at a time. An element is accepted, then applied by a
// read-modify-write of the position memory; an element that closes a cycle
// adds a write back to the cycle start. An element carrying product_end then
// runs the inversion sweep: one position memory read per point, then a drain
// step for the last inverse write. The emission walk follows: it scans the
// points, emits the points of each cycle or drops the walk, and sends the
// final beat, stalling whenever the result side holds off.
// The next item is taken once the final beat of the product is in the output
// register. The configuration port is always ready; it must be written
// only while idle, which the block itself does not enforce.
// Reset needs no clearing pass.
module permutation_cycle_composer #(
  parameter int MAX_POINTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  pcc_in_if.sink     in_chan,
  pcc_out_if.source  out_chan,
  pcc_cfg_if.sink    cfg_chan
);

  pcc_pkg::cmd_t cmd;
  pcc_pkg::sts_t sts;

  assign cfg_chan.ready = 1'b1;

  pcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcc_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_element       (in_chan.element),
    .in_cycle_end     (in_chan.cycle_end),
    .in_product_end   (in_chan.product_end),
    .cfg_wr           (cfg_chan.valid),
    .cfg_data         (cfg_chan.data),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_point        (out_chan.point),
    .out_closes_cycle (out_chan.closes_cycle),
    .out_is_identity  (out_chan.is_identity),
    .out_last         (out_chan.last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

[rtl/pcc_checker.sv]
// Port-level checks for the permutation cycle composer, bound to the top level.
// Depends on pcc_pkg for the field widths.
module pcc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_product_end,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pcc_pkg::POINT_W-1:0]  out_point,
  input logic                         out_closes_cycle,
  input logic                         out_is_identity,
  input logic                         out_last
);

  // A result beat stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn before it was taken");

  // Every accepted beat keeps the input side closed in the following cycle.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again straight after a beat");

  // The end of a product starts the sweep, so the input stays closed longer.
  a_pe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_product_end |=> !in_ready ##1 !in_ready)
    else $error("input reopened too early after the end of a product");

  // The identity marker is a lone beat with no point in it.
  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_identity |-> out_last && !out_closes_cycle && (out_point == '0))
    else $error("malformed identity marker");

  // The final point of a product always closes its cycle.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !out_is_identity |-> out_closes_cycle)
    else $error("final point leaves its cycle open");

endmodule

bind permutation_cycle_composer pcc_checker u_pcc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_product_end   (in_chan.product_end),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_point        (out_chan.point),
  .out_closes_cycle (out_chan.closes_cycle),
  .out_is_identity  (out_chan.is_identity),
  .out_last         (out_chan.last)
);
